// ===== rtl/jmp_pkg.sv =====
// shared types and constants for the jpeg marker probe
`timescale 1ns / 1ps
`default_nettype none

package jmp_pkg;

    typedef logic [2:0] t_status;

    // status codes and internal verdict codes share one encoding
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_NOT_JPEG    = 3'd1;
    localparam t_status ST_PROGRESSIVE = 3'd2;
    localparam t_status ST_UNSUPPORTED = 3'd3;
    localparam t_status ST_TRUNCATED   = 3'd4;
    localparam t_status V_SCAN         = 3'd5;
    localparam t_status V_UNDECIDED    = 3'd7;

    localparam logic [7:0] TAIL_WINDOW_RESET = 8'd64;

    // marker byte values
    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_TEM    = 8'h01;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_SOF3   = 8'hC3;
    localparam logic [7:0] MK_SOF5   = 8'hC5;
    localparam logic [7:0] MK_SOF7   = 8'hC7;
    localparam logic [7:0] MK_SOF9   = 8'hC9;
    localparam logic [7:0] MK_SOF15  = 8'hCF;
    localparam logic [7:0] MK_RST0   = 8'hD0;
    localparam logic [7:0] MK_RST7   = 8'hD7;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_SOS    = 8'hDA;

endpackage

`default_nettype wire

// ===== rtl/jpeg_marker_probe_core.sv =====
// jpeg marker probe top level: config register, walker and result buffer
// a file's status is registered on its last byte, into the skid slot if stalled
// throughput: one byte per cycle; the input stalls only when both result slots
//   (output register and skid register) are full
// reset: synchronous active low; tail window returns to 64 and the walker to
//   the start of a new file, which it also does after every last byte
`timescale 1ns / 1ps
`default_nettype none

module jpeg_marker_probe_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output jmp_pkg::t_status      o_status
);
    import jmp_pkg::*;

    logic [7:0] r_tail_window;
    logic       in_accept;
    logic       push;
    t_status    step_status;

    logic       r_out_valid, n_out_valid;
    t_status    r_out_status, n_out_status;
    logic       r_skid_valid, n_skid_valid;
    t_status    r_skid_status, n_skid_status;

    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign push        = in_accept && i_last;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_window <= TAIL_WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_tail_window <= i_cfg_data;
        end
    end

    jmp_walker u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_tail_window (r_tail_window),
        .o_status      (step_status)
    );

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_skid_valid  = r_skid_valid;
        n_skid_status = r_skid_status;
        if (!r_out_valid || !i_out_stall) begin
            // output slot frees up: drain skid first, else take the new status
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_status = r_skid_status;
                n_skid_valid = 1'b0;
            end else if (push) begin
                n_out_valid  = 1'b1;
                n_out_status = step_status;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (push) begin
            n_skid_valid  = 1'b1;
            n_skid_status = step_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_status  <= n_out_status;
        r_skid_status <= n_skid_status;
    end

endmodule

`default_nettype wire

// ===== rtl/jmp_walker.sv =====
// marker segment walker: per-byte state update and end-of-file status
`timescale 1ns / 1ps
`default_nettype none

module jmp_walker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_last,
    input  wire logic [7:0]       i_tail_window,
    output jmp_pkg::t_status      o_status
);
    import jmp_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_PREFIX,
        PH_FILL,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bytes_seen, n_bytes_seen;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_len_hi, n_len_hi;
    t_status     r_verdict, n_verdict;
    logic        r_prev_fill, n_prev_fill;
    logic [7:0]  r_pair_dist, n_pair_dist;

    logic [15:0] len_full;
    logic [15:0] skip_dec;
    logic        pair_in_window;

    assign len_full = {r_len_hi, i_data_byte};
    assign skip_dec = r_skip - 16'd1;

    always_comb begin
        n_phase   = r_phase;
        n_skip    = r_skip;
        n_len_hi  = r_len_hi;
        n_verdict = r_verdict;

        // end-of-image pair tracking runs regardless of phase
        n_pair_dist = (r_pair_dist != 8'hFF) ? r_pair_dist + 8'd1 : r_pair_dist;
        if (i_data_byte == MK_EOI && r_prev_fill) begin
            n_pair_dist = 8'd0;
        end
        n_prev_fill  = (i_data_byte == MK_PREFIX) && (r_bytes_seen >= 3'd2);
        n_bytes_seen = (r_bytes_seen < 3'd4) ? r_bytes_seen + 3'd1 : r_bytes_seen;

        unique case (r_phase)
            PH_HDR0: begin
                if (i_data_byte != MK_PREFIX) begin
                    n_verdict = ST_NOT_JPEG;
                    n_phase   = PH_DONE;
                end else begin
                    n_phase = PH_HDR1;
                end
            end
            PH_HDR1: begin
                if (i_data_byte != MK_SOI) begin
                    n_verdict = ST_NOT_JPEG;
                    n_phase   = PH_DONE;
                end else begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_PREFIX: begin
                // a bad prefix on the final byte is left undecided (truncated)
                if (!i_last) begin
                    if (i_data_byte != MK_PREFIX) begin
                        n_verdict = ST_NOT_JPEG;
                        n_phase   = PH_DONE;
                    end else begin
                        n_phase = PH_FILL;
                    end
                end
            end
            PH_FILL: begin
                if (i_data_byte != MK_PREFIX) begin
                    case (i_data_byte) inside
                        MK_TEM, MK_SOI, [MK_RST0:MK_RST7]: n_phase = PH_PREFIX;
                        MK_EOI: begin
                            n_verdict = ST_TRUNCATED;
                            n_phase   = PH_DONE;
                        end
                        MK_SOS: begin
                            n_verdict = V_SCAN;
                            n_phase   = PH_DONE;
                        end
                        MK_SOF2: begin
                            n_verdict = ST_PROGRESSIVE;
                            n_phase   = PH_DONE;
                        end
                        MK_SOF3, [MK_SOF5:MK_SOF7], [MK_SOF9:MK_SOF15]: begin
                            n_verdict = ST_UNSUPPORTED;
                            n_phase   = PH_DONE;
                        end
                        default: n_phase = PH_LEN_HI;
                    endcase
                end
            end
            PH_LEN_HI: begin
                n_len_hi = i_data_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (len_full < 16'd2) begin
                    n_verdict = ST_NOT_JPEG;
                    n_phase   = PH_DONE;
                end else begin
                    n_skip  = len_full - 16'd2;
                    n_phase = (len_full != 16'd2) ? PH_SKIP : PH_PREFIX;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: n_phase = PH_DONE;
        endcase
    end

    // a pair counts when distance + 2 <= tail window
    assign pair_in_window = ({1'b0, n_pair_dist} + 9'd2) <= {1'b0, i_tail_window};

    always_comb begin
        if (n_bytes_seen < 3'd4) begin
            o_status = ST_NOT_JPEG;
        end else if (n_verdict == V_UNDECIDED) begin
            o_status = ST_TRUNCATED;
        end else if (n_verdict == V_SCAN) begin
            o_status = pair_in_window ? ST_OK : ST_TRUNCATED;
        end else begin
            o_status = n_verdict;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase      <= PH_HDR0;
            r_bytes_seen <= 3'd0;
            r_skip       <= 16'd0;
            r_len_hi     <= 8'd0;
            r_verdict    <= V_UNDECIDED;
            r_prev_fill  <= 1'b0;
            r_pair_dist  <= 8'hFF;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bytes_seen <= n_bytes_seen;
            r_skip       <= n_skip;
            r_len_hi     <= n_len_hi;
            r_verdict    <= n_verdict;
            r_prev_fill  <= n_prev_fill;
            r_pair_dist  <= n_pair_dist;
        end
    end

endmodule

`default_nettype wire

// ===== dv/jpeg_marker_probe_core_tb.sv =====
// self-checking testbench for the jpeg marker probe core
`timescale 1ns / 1ps

module jpeg_marker_probe_core_tb;
    import jmp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 250;
    localparam int IDLE_PCT      = 18;
    localparam int HOLD_CYCLES   = 200;

    // marker bytes that carry a length segment
    localparam logic [7:0] MK_SOF0 = 8'hC0;
    localparam logic [7:0] MK_SOF1 = 8'hC1;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_JPG  = 8'hC8;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_DRI  = 8'hDD;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_COM  = 8'hFE;

    typedef enum logic [2:0] {
        WK_HDR0, WK_HDR1, WK_PREFIX, WK_FILL, WK_LEN_HI, WK_LEN_LO, WK_SKIP, WK_DONE
    } t_walk;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [7:0]       i_cfg_data  = 8'h00;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_last      = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_status          o_status;

    jpeg_marker_probe_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status)
    );

    // walker copy used for prediction
    logic [7:0]  tail_win;
    t_walk       walk_phase;
    logic [2:0]  seen_cnt;
    logic [15:0] skip_cnt;
    logic [7:0]  len_hi;
    t_status     walk_verdict;
    logic        after_ff;
    logic [7:0]  eoi_dist;

    t_status     status_q[$];
    logic [7:0]  file_bytes[$];

    int err_cnt       = 0;
    int bytes_sent    = 0;
    int files_sent    = 0;
    int status_seen   = 0;
    int windows_used  = 0;
    int hold_len      = 0;
    bit quiet         = 1'b0;
    int status_hits[5];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("jpeg_marker_probe_core regression: fail");
        $finish;
    end

    function void clear_walk();
        walk_phase   = WK_HDR0;
        seen_cnt     = 3'd0;
        skip_cnt     = 16'd0;
        len_hi       = 8'd0;
        walk_verdict = V_UNDECIDED;
        after_ff     = 1'b0;
        eoi_dist     = 8'd255;
    endfunction

    function void walk_byte(input logic [7:0] b, input logic fin);
        logic [2:0]  pos;
        logic [15:0] seg_len;
        t_status     st;
        pos = seen_cnt;
        if (eoi_dist != 8'd255) eoi_dist = eoi_dist + 8'd1;
        if (b == MK_EOI && after_ff) eoi_dist = 8'd0;
        after_ff = (b == MK_PREFIX) && (pos >= 3'd2);
        if (seen_cnt < 3'd4) seen_cnt = seen_cnt + 3'd1;

        case (walk_phase)
            WK_HDR0: begin
                if (b != MK_PREFIX) begin
                    walk_verdict = ST_NOT_JPEG;
                    walk_phase   = WK_DONE;
                end else begin
                    walk_phase = WK_HDR1;
                end
            end
            WK_HDR1: begin
                if (b != MK_SOI) begin
                    walk_verdict = ST_NOT_JPEG;
                    walk_phase   = WK_DONE;
                end else begin
                    walk_phase = WK_PREFIX;
                end
            end
            WK_PREFIX: begin
                // a bad prefix on the final byte is left undecided, i.e. truncated
                if (!fin) begin
                    if (b != MK_PREFIX) begin
                        walk_verdict = ST_NOT_JPEG;
                        walk_phase   = WK_DONE;
                    end else begin
                        walk_phase = WK_FILL;
                    end
                end
            end
            WK_FILL: begin
                if (b == MK_PREFIX) begin
                    walk_phase = WK_FILL;
                end else if (b == MK_SOI || b == MK_TEM ||
                             (b >= MK_RST0 && b <= MK_RST7)) begin
                    walk_phase = WK_PREFIX;
                end else if (b == MK_EOI) begin
                    walk_verdict = ST_TRUNCATED;
                    walk_phase   = WK_DONE;
                end else if (b == MK_SOS) begin
                    walk_verdict = V_SCAN;
                    walk_phase   = WK_DONE;
                end else if (b == MK_SOF2) begin
                    walk_verdict = ST_PROGRESSIVE;
                    walk_phase   = WK_DONE;
                end else if (b == MK_SOF3 ||
                             (b >= MK_SOF5 && b <= MK_SOF15 && b != MK_JPG)) begin
                    walk_verdict = ST_UNSUPPORTED;
                    walk_phase   = WK_DONE;
                end else begin
                    walk_phase = WK_LEN_HI;
                end
            end
            WK_LEN_HI: begin
                len_hi     = b;
                walk_phase = WK_LEN_LO;
            end
            WK_LEN_LO: begin
                seg_len = {len_hi, b};
                if (seg_len < 16'd2) begin
                    walk_verdict = ST_NOT_JPEG;
                    walk_phase   = WK_DONE;
                end else begin
                    skip_cnt   = seg_len - 16'd2;
                    walk_phase = (skip_cnt != 16'd0) ? WK_SKIP : WK_PREFIX;
                end
            end
            WK_SKIP: begin
                skip_cnt = skip_cnt - 16'd1;
                if (skip_cnt == 16'd0) walk_phase = WK_PREFIX;
            end
            default: ;
        endcase

        if (fin) begin
            if (seen_cnt < 3'd4)
                st = ST_NOT_JPEG;
            else if (walk_verdict == V_UNDECIDED)
                st = ST_TRUNCATED;
            else if (walk_verdict == V_SCAN)
                st = ({1'b0, eoi_dist} + 9'd2 <= {1'b0, tail_win}) ? ST_OK : ST_TRUNCATED;
            else
                st = walk_verdict;
            status_q.push_back(st);
            clear_walk();
        end
    endfunction

    // follow config writes and accepted bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tail_win = TAIL_WINDOW_RESET;
            clear_walk();
        end else begin
            if (i_cfg_we) tail_win = i_cfg_data;
            if (i_in_valid && !o_in_stall) walk_byte(i_data_byte, i_last);
        end
    end

    // compare every delivered status with the oldest prediction
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                $error("status: no status expected, got %0d", o_status);
                err_cnt++;
            end else begin
                want = status_q.pop_front();
                status_seen++;
                if (want <= ST_TRUNCATED) status_hits[want]++;
                if (o_status !== want) begin
                    $error("status: expected %0d, got %0d", want, o_status);
                    err_cnt++;
                end
            end
        end
    end

    // result side stall: random, quiet, or a long hold-off
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_out_stall <= 1'b1;
            hold_len = hold_len - 1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    task send_byte(input logic [7:0] b, input logic fin);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last      <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task send_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task set_window(input logic [7:0] w);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        windows_used++;
    endtask

    function void push_random(input int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // prefix with occasional fill bytes in front of the marker
    function void push_prefix();
        if ($urandom_range(0, 9) < 2)
            repeat ($urandom_range(1, 3)) file_bytes.push_back(MK_PREFIX);
        file_bytes.push_back(MK_PREFIX);
    endfunction

    // scanned file whose end-of-image pair is followed by tail non-FF bytes
    function void build_scan_file(input int tail);
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOS, MK_PREFIX, MK_EOI};
        repeat (tail) file_bytes.push_back(8'($urandom_range(0, 254)));
    endfunction

    function void build_walk_file();
        int          pick;
        int          nseg;
        int          keep;
        logic [15:0] seg_len;
        logic [7:0]  mk;
        bit          cut;
        file_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            push_random($urandom_range(1, 10));
            return;
        end
        file_bytes = {MK_PREFIX, MK_SOI};
        nseg = $urandom_range(0, 4);
        cut  = 1'b0;
        for (int s = 0; s < nseg && !cut; s++) begin
            push_prefix();
            if ($urandom_range(0, 99) < 25) begin
                case ($urandom_range(0, 2))
                    0:       file_bytes.push_back(8'(MK_RST0 + $urandom_range(0, 7)));
                    1:       file_bytes.push_back(MK_TEM);
                    default: file_bytes.push_back(MK_SOI);
                endcase
            end else begin
                case ($urandom_range(0, 7))
                    0:       mk = MK_SOF0;
                    1:       mk = MK_SOF1;
                    2:       mk = MK_DHT;
                    3:       mk = MK_JPG;
                    4:       mk = MK_DQT;
                    5:       mk = MK_DRI;
                    6:       mk = 8'(MK_APP0 + $urandom_range(0, 15));
                    default: mk = MK_COM;
                endcase
                file_bytes.push_back(mk);
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    seg_len = 16'($urandom_range(0, 1));
                end else if (pick == 1) begin
                    // full-range length; the file is cut off at most six bytes after it
                    seg_len = 16'($urandom_range(0, 65535));
                    cut     = 1'b1;
                end else begin
                    seg_len = 16'($urandom_range(2, 12));
                end
                file_bytes.push_back(seg_len[15:8]);
                file_bytes.push_back(seg_len[7:0]);
                if (cut)
                    push_random($urandom_range(0, 6));
                else if (seg_len >= 16'd2)
                    push_random(int'(seg_len) - 2);
            end
        end
        if (!cut) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                push_prefix();
                file_bytes.push_back(MK_SOS);
                push_random($urandom_range(0, 12));
                if ($urandom_range(0, 9) < 8) begin
                    file_bytes.push_back(MK_PREFIX);
                    file_bytes.push_back(MK_EOI);
                end
                push_random(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 70));
            end else if (pick < 70) begin
                push_prefix();
                file_bytes.push_back(MK_SOF2);
                push_random($urandom_range(0, 4));
            end else if (pick < 80) begin
                push_prefix();
                keep = $urandom_range(0, 10);
                if (keep == 0)
                    file_bytes.push_back(MK_SOF3);
                else if (keep < 4)
                    file_bytes.push_back(8'(MK_SOF5 + keep - 1));
                else
                    file_bytes.push_back(8'(MK_SOF9 + keep - 4));
                push_random($urandom_range(0, 4));
            end else if (pick < 86) begin
                push_prefix();
                file_bytes.push_back(MK_EOI);
                push_random($urandom_range(0, 4));
            end else if (pick < 93) begin
                // non-FF byte where a prefix is due, sometimes as the final byte
                file_bytes.push_back(8'($urandom_range(0, 254)));
                push_random($urandom_range(0, 4));
            end else begin
                push_prefix();
            end
        end
        if ($urandom_range(0, 99) < 5)
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 5) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
        end
    endfunction

    task test_marker_cases();
        file_bytes = {MK_PREFIX};                                  // short file
        send_file();
        file_bytes = {8'h00, MK_SOI, MK_PREFIX, MK_SOS};           // bad start mark
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_PREFIX, MK_RST0, MK_PREFIX, MK_TEM,
                      MK_PREFIX, MK_APP0, 8'h00, 8'h02, MK_PREFIX, MK_SOS, MK_PREFIX, MK_EOI};
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF2};
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF15};
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_EOI};        // end before scan
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, 8'h12, 8'hFE};             // bad prefix
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_APP0, 8'h00, 8'h02, 8'h7F};
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_APP0, 8'h00, 8'h01};  // length below 2
        send_file();
        file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_APP0, 8'hFF, 8'hFF};  // ends in length
        send_file();
    endtask

    // pair distance just past each window edge, and right at it for windows from 2 to below the widest
    task test_tail_window();
        logic [7:0] wins[5];
        wins = '{8'd0, 8'd1, 8'd2, 8'($urandom_range(3, 30)), 8'd255};
        foreach (wins[k]) begin
            set_window(wins[k]);
            if (wins[k] != 8'd255) begin
                build_scan_file((wins[k] >= 8'd2) ? int'(wins[k]) - 2 : 0);
                send_file();
            end
            build_scan_file((wins[k] >= 8'd1) ? int'(wins[k]) - 1 : 1);
            send_file();
        end
    endtask

    task test_random_walks();
        int          start;
        int          chunk;
        logic [7:0]  wins[5];
        start = bytes_sent;
        wins  = '{TAIL_WINDOW_RESET, 8'($urandom_range(1, 255)), 8'd255, 8'd1,
                  8'($urandom_range(0, 255))};
        chunk = 0;
        quiet = 1'b1;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (bytes_sent - start >= 100) quiet = 1'b0;
            if (bytes_sent - start >= chunk * (RANDOM_BYTES / 5) && chunk < 5) begin
                set_window(wins[chunk]);
                chunk++;
            end
            build_walk_file();
            send_file();
        end
        quiet = 1'b0;
    endtask

    // results held back long enough that the core has to stall its input
    task test_result_backpressure();
        wait_idle();
        hold_len = HOLD_CYCLES;
        repeat (12) begin
            file_bytes = {MK_PREFIX, MK_SOI, MK_PREFIX, MK_SOF2};
            send_file();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_marker_cases();
        test_tail_window();
        test_random_walks();
        test_result_backpressure();
        wait_idle();
        repeat (5) @(posedge i_clk);
        $display("covered %0d files, %0d bytes, %0d tail window writes, %0d statuses checked",
                 files_sent, bytes_sent, windows_used, status_seen);
        $display("status mix: ok %0d, not jpeg %0d, progressive %0d, unsupported %0d, %s %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 "truncated", status_hits[4]);
        if (err_cnt == 0 && status_q.size() == 0)
            $display("jpeg_marker_probe_core regression: pass");
        else
            $display("jpeg_marker_probe_core regression: fail");
        $finish;
    end

endmodule
